FILE: rtl/i2p_pkg.sv
package i2p_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned RESQ_DEPTH  = 2;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TERM   = 8'h00;

  typedef enum logic [2:0] {
    K_ALNUM  = 3'd0,
    K_LPAREN = 3'd1,
    K_RPAREN = 3'd2,
    K_OPER   = 3'd3,
    K_END    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] sym;
    logic [1:0] prec;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } res_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    unique case (c)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

FILE: rtl/i2p_front.sv
module i2p_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    symbol_i,
  input  logic          end_marker_i,
  output logic          cmd_empty_o,
  input  logic          cmd_pop_i,
  output i2p_pkg::cmd_t cmd_o
);

  localparam int unsigned PTR_W = $clog2(i2p_pkg::CMDQ_DEPTH);
  localparam int unsigned QC_W  = $clog2(i2p_pkg::CMDQ_DEPTH + 1);

  i2p_pkg::cmd_t    q_mem [i2p_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  i2p_pkg::cmd_t    cls;
  logic             do_wr, do_rd;

  always_comb begin
    cls.sym  = symbol_i;
    cls.prec = i2p_pkg::prec_of(symbol_i);
    priority if (end_marker_i) begin
      cls.kind = i2p_pkg::K_END;
    end else if (i2p_pkg::is_alnum(symbol_i)) begin
      cls.kind = i2p_pkg::K_ALNUM;
    end else if (symbol_i == i2p_pkg::CH_LPAREN) begin
      cls.kind = i2p_pkg::K_LPAREN;
    end else if (symbol_i == i2p_pkg::CH_RPAREN) begin
      cls.kind = i2p_pkg::K_RPAREN;
    end else begin
      cls.kind = i2p_pkg::K_OPER;
    end
  end

  assign full        = (cnt_q == QC_W'(i2p_pkg::CMDQ_DEPTH));
  assign cmd_empty_o = (cnt_q == '0);
  assign do_wr       = push && !full;
  assign do_rd       = cmd_pop_i && !cmd_empty_o;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_d = (wr_q == PTR_W'(i2p_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_d = (rd_q == PTR_W'(i2p_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

FILE: rtl/i2p_back.sv
module i2p_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  i2p_pkg::cmd_t cmd_i,
  output logic          res_push_o,
  input  logic          res_full_i,
  output i2p_pkg::res_t res_o
);

  localparam int unsigned CW = i2p_pkg::CNT_W;
  localparam int unsigned IW = i2p_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e        state_q, state_d;
  i2p_pkg::cmd_t cmd_q;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    top_q, top_d;
  logic [7:0]    stack_mem [i2p_pkg::STACK_DEPTH];
  logic [CW-1:0] cnt_m1, rd_ptr;
  logic [7:0]    nxt_q;
  logic          has, only_one, room;
  logic          do_pop, do_push, done;
  logic          wr_en;

  assign cnt_m1   = count_q - CW'(1);
  assign rd_ptr   = count_d - CW'(2);
  assign has      = (count_q != '0);
  assign only_one = (count_q == CW'(1));
  assign room     = (count_q < CW'(i2p_pkg::STACK_DEPTH));
  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;

  always_comb begin
    do_pop     = 1'b0;
    do_push    = 1'b0;
    done       = 1'b0;
    res_push_o = 1'b0;
    res_o.ch   = top_q;
    res_o.last = 1'b0;
    if (state_q == S_RUN) begin
      unique case (cmd_q.kind)
        i2p_pkg::K_END: begin
          if (has) begin
            res_push_o = !res_full_i;
            do_pop     = !res_full_i;
          end else begin
            res_o.ch   = i2p_pkg::CH_TERM;
            res_o.last = 1'b1;
            res_push_o = !res_full_i;
            done       = !res_full_i;
          end
        end
        i2p_pkg::K_ALNUM: begin
          res_o.ch   = cmd_q.sym;
          res_o.last = 1'b1;
          res_push_o = !res_full_i;
          done       = !res_full_i;
        end
        i2p_pkg::K_LPAREN: begin
          do_push = 1'b1;
          done    = 1'b1;
        end
        i2p_pkg::K_RPAREN: begin
          if (has && (top_q != i2p_pkg::CH_LPAREN)) begin
            res_o.last = only_one || (nxt_q == i2p_pkg::CH_LPAREN);
            res_push_o = !res_full_i;
            do_pop     = !res_full_i;
          end else begin
            do_pop = has;
            done   = 1'b1;
          end
        end
        i2p_pkg::K_OPER: begin
          if (has && (i2p_pkg::prec_of(top_q) >= cmd_q.prec)) begin
            res_o.last = only_one || (i2p_pkg::prec_of(nxt_q) < cmd_q.prec);
            res_push_o = !res_full_i;
            do_pop     = !res_full_i;
          end else begin
            do_push = 1'b1;
            done    = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign wr_en = do_push && room && has;

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    state_d = state_q;
    if (do_pop) begin
      count_d = cnt_m1;
      top_d   = nxt_q;
    end else if (do_push && room) begin
      count_d = count_q + CW'(1);
      top_d   = cmd_q.sym;
    end
    unique case (state_q)
      S_IDLE:  state_d = cmd_empty_i ? S_IDLE : S_RUN;
      S_RUN:   state_d = done ? S_IDLE : S_RUN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (wr_en) begin
      stack_mem[cnt_m1[IW-1:0]] <= top_q;
      nxt_q                     <= top_q;
    end else begin
      nxt_q <= stack_mem[rd_ptr[IW-1:0]];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(i2p_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written into full queue");

  a_alnum_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && cmd_q.kind == i2p_pkg::K_ALNUM && !res_full_i)
    |=> (state_q == S_IDLE))
    else $error("pass-through character did not finish");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE))
    else $error("command taken while busy");
`endif

endmodule

FILE: rtl/i2p_out_fifo.sv
module i2p_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  output logic          res_full_o,
  input  i2p_pkg::res_t res_i,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_char_o,
  output logic          last_in_run_o
);

  localparam int unsigned PTR_W = $clog2(i2p_pkg::RESQ_DEPTH);
  localparam int unsigned QC_W  = $clog2(i2p_pkg::RESQ_DEPTH + 1);

  i2p_pkg::res_t    q_mem [i2p_pkg::RESQ_DEPTH];
  i2p_pkg::res_t    head;
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign res_full_o    = (cnt_q == QC_W'(i2p_pkg::RESQ_DEPTH));
  assign empty         = (cnt_q == '0);
  assign do_wr         = res_push_i && !res_full_o;
  assign do_rd         = pop && !empty;
  assign head          = q_mem[rd_q];
  assign out_char_o    = head.ch;
  assign last_in_run_o = head.last;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_d = (wr_q == PTR_W'(i2p_pkg::RESQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_d = (rd_q == PTR_W'(i2p_pkg::RESQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      q_mem[wr_q] <= res_i;
    end
  end

endmodule

FILE: rtl/infix_to_postfix_converter.sv
// Shunting-yard infix-to-postfix converter. Write one expression character per
// transaction on the input queue (push/full); postfix characters come out of
// the result queue (empty/pop), last_in_run_o marking the final result of each
// input and a zero character ending the expression after the end marker. A
// two-entry command queue decouples the classifying front end from the stack
// engine. The stack engine takes a command from the queue while idle and then
// does one step per cycle on the operator stack while the result queue is not
// full; the stack keeps its top in a register and reads the entry below it
// through a registered port. Letters, digits and '(' are handled in a single
// step, while an operator, ')' or the end marker first pop stack entries, one
// per step. The first result of an input passes the command queue and the
// command register before it reaches the result queue and its ports.
module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       end_marker_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_in_run_o
);

  i2p_pkg::cmd_t cmd;
  i2p_pkg::res_t res;
  logic          cmd_empty, cmd_pop;
  logic          res_push, res_full;

  i2p_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .symbol_i     (symbol_i),
    .end_marker_i (end_marker_i),
    .cmd_empty_o  (cmd_empty),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  i2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res)
  );

  i2p_out_fifo u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_push_i    (res_push),
    .res_full_o    (res_full),
    .res_i         (res),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule

FILE: dv/postfix_checker.sv
module postfix_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  symbol_i,
  input  logic        end_marker_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_in_run_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } postfix_char_t;

  logic [7:0]    op_stack [i2p_pkg::STACK_DEPTH];
  int unsigned   op_count;
  postfix_char_t postfix_q [$];
  postfix_char_t want;
  int unsigned   fails;

  function automatic int unsigned rank_of(input logic [7:0] c);
    case (c)
      i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: return 1;
      i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH: return 2;
      i2p_pkg::CH_CARET:                   return 3;
      default:                             return 0;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    postfix_q.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void pop_and_emit();
    op_count--;
    emit_char(op_stack[op_count]);
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (op_count < i2p_pkg::STACK_DEPTH) begin
      op_stack[op_count] = c;
      op_count++;
    end
  endfunction

  function automatic void convert_symbol(input logic [7:0] sym, input logic endm);
    int unsigned   before_n;
    int unsigned   rank;
    postfix_char_t tail;
    before_n = postfix_q.size();
    if (endm) begin
      while (op_count > 0) pop_and_emit();
      emit_char(i2p_pkg::CH_TERM);
    end else if (is_operand(sym)) begin
      emit_char(sym);
    end else if (sym == i2p_pkg::CH_LPAREN) begin
      push_op(sym);
    end else if (sym == i2p_pkg::CH_RPAREN) begin
      while (op_count > 0 && op_stack[op_count-1] != i2p_pkg::CH_LPAREN)
        pop_and_emit();
      if (op_count > 0) op_count--;
    end else begin
      rank = rank_of(sym);
      while (op_count > 0 && rank_of(op_stack[op_count-1]) >= rank) pop_and_emit();
      push_op(sym);
    end
    if (postfix_q.size() > before_n) begin
      tail = postfix_q.pop_back();
      tail.last = 1'b1;
      postfix_q.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_count = 0;
      postfix_q.delete();
      fails = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result: out_char=%02h last_in_run=%0b",
                 out_char_i, last_in_run_i);
          fails++;
        end else begin
          want = postfix_q.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char mismatch: expected %02h, actual %02h", want.ch, out_char_i);
            fails++;
          end
          if (last_in_run_i !== want.last) begin
            $error("last_in_run mismatch: expected %0b, actual %0b",
                   want.last, last_in_run_i);
            fails++;
          end
        end
      end
      if (push_i && !full_i) convert_symbol(symbol_i, end_marker_i);
    end
    fail_count_o  <= fails;
    outstanding_o <= postfix_q.size();
  end

endmodule

FILE: dv/infix_to_postfix_converter_tb.sv
module infix_to_postfix_converter_tb;

  localparam int unsigned ITEMS     = 430;
  localparam int unsigned LIMIT     = 300000;
  localparam int unsigned END_DRAIN = 20;

  typedef enum int unsigned {
    RX_DRAIN,
    RX_COIN,
    RX_TRICKLE,
    RX_STALL
  } rx_mode_e;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic [7:0] symbol       = 8'h00;
  logic       end_marker   = 1'b0;
  logic       empty;
  logic       pop          = 1'b0;
  logic [7:0] out_char;
  logic       last_in_run;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;

  logic [7:0] operators [5] = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS, i2p_pkg::CH_STAR,
                                i2p_pkg::CH_SLASH, i2p_pkg::CH_CARET};

  infix_to_postfix_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .symbol_i      (symbol),
    .end_marker_i  (end_marker),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char),
    .last_in_run_o (last_in_run)
  );

  postfix_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .symbol_i      (symbol),
    .end_marker_i  (end_marker),
    .empty_i       (empty),
    .pop_i         (pop),
    .out_char_i    (out_char),
    .last_in_run_i (last_in_run),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("infix_to_postfix_converter test failed");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] sym, input logic endm);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    push       <= 1'b1;
    symbol     <= sym;
    end_marker <= endm;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    return operators[3'($urandom_range(0, 4))];
  endfunction

  // nest 30 to 40 opens and operators, often past the stack depth, then end the expression
  task automatic deep_nest();
    int unsigned n;
    bit          prev_open;
    n = $urandom_range(30, 40);
    prev_open = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (prev_open && $urandom_range(0, 1)) begin
        send_item(pick_operator(), 1'b0);
        prev_open = 1'b0;
      end else begin
        send_item(i2p_pkg::CH_LPAREN, 1'b0);
        prev_open = 1'b1;
      end
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_random();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 1)       deep_nest();
    else if (roll < 37) send_item(pick_operand(), 1'b0);
    else if (roll < 60) send_item(pick_operator(), 1'b0);
    else if (roll < 72) send_item(i2p_pkg::CH_LPAREN, 1'b0);
    else if (roll < 82) send_item(i2p_pkg::CH_RPAREN, 1'b0);
    else if (roll < 89) send_item(8'($urandom_range(0, 255)), 1'b1);
    else                send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    rx_mode_e    mode;
    int unsigned seg;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = (mode == RX_STALL) ? $urandom_range(5, 25) : $urandom_range(8, 60);
      repeat (seg) begin
        @(negedge clk_i);
        case (mode)
          RX_DRAIN:   pop <= 1'b1;
          RX_COIN:    pop <= 1'($urandom_range(0, 1));
          RX_TRICKLE: pop <= ($urandom_range(0, 7) == 0);
          default:    pop <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text("a+b*c^(Z-9)/0");
    send_item(8'h7A, 1'b1);
    send_item(i2p_pkg::CH_TERM, 1'b1);
    send_text("+)");
    send_text("(*%");
    send_item(i2p_pkg::CH_TERM, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);

    deep_nest();
    while (sent_count < ITEMS) send_random();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    push <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (END_DRAIN) @(negedge clk_i);
    if (fail_count == 0)
      $display("infix_to_postfix_converter test passed");
    else
      $display("infix_to_postfix_converter test failed");
    $finish;
  end

endmodule
